>>> sv/rfa_pkg.sv
// Package for the rational fraction ALU: widths, command and status codes,
// and sequencer state type. Depends on nothing.
package rfa_pkg;
   localparam int OPERAND_WIDTH = 32;
   localparam int RES_W = 64;
   localparam int CNT_W = $clog2(RES_W);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_ZERO_DEN = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_GCD_CHK, S_GCD_WAIT, S_Q1, S_Q2, S_MUL_LCM, S_MUL_SL, S_MUL_SR,
      S_COMBINE, S_MUL_N, S_MUL_D, S_RED_START, S_RED_N, S_RED_D, S_FIN
   } state_type;
endpackage

>>> sv/rfa_div.sv
// Shared restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on rfa_pkg for widths.
module rfa_div import rfa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [RES_W-1:0] dividend,
   input  logic [RES_W-1:0] divisor,
   output logic [RES_W-1:0] quotient,
   output logic [RES_W-1:0] remainder,
   output logic             done
);
   logic [RES_W-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [RES_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[RES_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? RES_W'(trial - {1'b0, dsr_ff}) : trial[RES_W-1:0];
         quo_in = {quo_ff[RES_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RES_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule

>>> sv/rational_fraction_alu_top.sv
// Top level of the rational fraction ALU: request capture, sequencer,
// shared multiplier and result register. Depends on rfa_pkg and rfa_div.
//
// The block takes one request (start high while busy is low) holding two
// sign-magnitude fractions and a command, and returns exactly one response,
// shown on the rsp_ ports for a single cycle while rsp_valid is high. The
// receiver cannot stall, so it must capture the response in that cycle.
// Busy stays high from the cycle after a request until the response is shown,
// and a new request can be taken in the cycle the response appears. A single
// 64-bit divider producing one quotient bit per cycle does all Euclidean
// steps and all reductions, so latency is dominated by it; every Euclidean
// step also passes through a state that checks the remainder. Add and
// subtract find the gcd of the denominators and then the gcd of the result
// numerator and denominator; multiply and divide find only the latter.
// A zero result numerator or a sum overflow skips the final reduction.
// Requests with a zero denominator or a division by a zero fraction go
// straight from idle to the final state.
// Results are always reduced; a zero numerator gives denominator 1, and a
// zero result may keep a minus sign as the sign rules dictate.
module rational_fraction_alu_top import rfa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic [31:0]              req_num_a,
   input  logic [31:0]              req_den_a,
   input  logic                     req_neg_a,
   input  logic [31:0]              req_num_b,
   input  logic [31:0]              req_den_b,
   input  logic                     req_neg_b,
   output logic                     rsp_valid,
   output logic [63:0]              rsp_result_num,
   output logic [63:0]              rsp_result_den,
   output logic                     rsp_result_neg,
   output logic [1:0]               rsp_status
);
   localparam int OW = OPERAND_WIDTH;

   state_type state_ff, state_in;

   // Captured request operands, already cut to the operand width.
   logic [OW-1:0]    na_ff, na_in, da_ff, da_in, nb_ff, nb_in, db_ff, db_in;
   logic             sa_ff, sa_in, sb_ff, sb_in;
   command_type      cmd_ff, cmd_in;

   // Working registers of the sequencer.
   logic [RES_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [OW-1:0]    q1_ff, q1_in, q2_ff, q2_in;
   logic [RES_W-1:0] num_ff, num_in, den_ff, den_in, sl_ff, sl_in;
   logic             neg_ff, neg_in, red_ff, red_in;
   status_type       st_ff, st_in;

   // Divider launch registers.
   logic             go_ff, go_in;
   logic [RES_W-1:0] dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic [RES_W-1:0] div_quo, div_rem;
   logic             div_done;

   // Response registers.
   logic             vld_ff, vld_in;
   logic [RES_W-1:0] rnum_ff, rnum_in, rden_ff, rden_in;
   logic             rneg_ff, rneg_in;
   status_type       rst_ff, rst_in;

   // Shared multiplier, operands chosen by state; its product is always
   // written into a register before use.
   logic [OW-1:0]    mul_a, mul_b;
   logic [2*OW-1:0]  mul_p;
   logic [RES_W-1:0] prod;
   logic [RES_W:0]   sum;

   rfa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (go_ff),
      .dividend  (dvd_ff),
      .divisor   (dvs_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      case (state_ff)
         S_MUL_LCM: begin mul_a = q1_ff; mul_b = db_ff; end
         S_MUL_SL:  begin mul_a = na_ff; mul_b = q2_ff; end
         S_MUL_SR:  begin mul_a = nb_ff; mul_b = q1_ff; end
         S_MUL_N:   begin mul_a = na_ff; mul_b = (cmd_ff == CMD_DIV) ? db_ff : nb_ff; end
         S_MUL_D:   begin mul_a = da_ff; mul_b = (cmd_ff == CMD_DIV) ? nb_ff : db_ff; end
         default:   begin mul_a = '0;    mul_b = '0;    end
      endcase
      mul_p = mul_a * mul_b;
      prod  = RES_W'(mul_p);
      sum   = {1'b0, sl_ff} + {1'b0, num_ff};
   end

   always_comb begin
      state_in = state_ff;
      na_in = na_ff; da_in = da_ff; nb_in = nb_ff; db_in = db_ff;
      sa_in = sa_ff; sb_in = sb_ff; cmd_in = cmd_ff;
      x_in = x_ff; y_in = y_ff; q1_in = q1_ff; q2_in = q2_ff;
      num_in = num_ff; den_in = den_ff; sl_in = sl_ff;
      neg_in = neg_ff; red_in = red_ff; st_in = st_ff;
      go_in = 1'b0; dvd_in = dvd_ff; dvs_in = dvs_ff;
      vld_in = 1'b0;
      rnum_in = rnum_ff; rden_in = rden_ff; rneg_in = rneg_ff; rst_in = rst_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               na_in  = req_num_a[OW-1:0];
               da_in  = req_den_a[OW-1:0];
               nb_in  = req_num_b[OW-1:0];
               db_in  = req_den_b[OW-1:0];
               cmd_in = command_type'(req_command);
               sa_in  = req_neg_a;
               // Subtract is add with the sign of the second operand flipped.
               sb_in  = req_neg_b ^ (command_type'(req_command) == CMD_SUB);
               st_in  = ST_OK;
               if (req_den_a[OW-1:0] == '0 || req_den_b[OW-1:0] == '0) begin
                  st_in    = ST_ZERO_DEN;
                  state_in = S_FIN;
               end else if (command_type'(req_command) == CMD_DIV &&
                            req_num_b[OW-1:0] == '0) begin
                  st_in    = ST_DIV_ZERO;
                  state_in = S_FIN;
               end else if (req_command[1]) begin
                  state_in = S_MUL_N;
               end else begin
                  x_in     = RES_W'(req_den_a[OW-1:0]);
                  y_in     = RES_W'(req_den_b[OW-1:0]);
                  red_in   = 1'b0;
                  state_in = S_GCD_CHK;
               end
            end
         end
         S_GCD_CHK: begin
            go_in  = 1'b1;
            dvs_in = x_ff;
            if (y_ff != '0) begin
               dvd_in   = x_ff;
               dvs_in   = y_ff;
               state_in = S_GCD_WAIT;
            end else if (red_ff) begin
               dvd_in   = num_ff;
               state_in = S_RED_N;
            end else begin
               dvd_in   = RES_W'(da_ff);
               state_in = S_Q1;
            end
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_rem;
               state_in = S_GCD_CHK;
            end
         end
         S_Q1: begin
            if (div_done) begin
               q1_in    = div_quo[OW-1:0];
               go_in    = 1'b1;
               dvd_in   = RES_W'(db_ff);
               dvs_in   = x_ff;
               state_in = S_Q2;
            end
         end
         S_Q2: begin
            if (div_done) begin
               q2_in    = div_quo[OW-1:0];
               state_in = S_MUL_LCM;
            end
         end
         S_MUL_LCM: begin
            den_in   = prod;
            state_in = S_MUL_SL;
         end
         S_MUL_SL: begin
            sl_in    = prod;
            state_in = S_MUL_SR;
         end
         S_MUL_SR: begin
            num_in   = prod;
            state_in = S_COMBINE;
         end
         S_COMBINE: begin
            state_in = S_RED_START;
            if (sa_ff == sb_ff) begin
               neg_in = sa_ff;
               num_in = sum[RES_W-1:0];
               if (sum[RES_W]) begin
                  st_in    = ST_OVERFLOW;
                  state_in = S_FIN;
               end
            end else if (sl_ff >= num_ff) begin
               neg_in = sa_ff;
               num_in = sl_ff - num_ff;
            end else begin
               neg_in = sb_ff;
               num_in = num_ff - sl_ff;
            end
         end
         S_MUL_N: begin
            num_in   = prod;
            neg_in   = sa_ff ^ sb_ff;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            den_in   = prod;
            state_in = S_RED_START;
         end
         S_RED_START: begin
            if (num_ff == '0) begin
               den_in   = RES_W'(1);
               state_in = S_FIN;
            end else begin
               x_in     = num_ff;
               y_in     = den_ff;
               red_in   = 1'b1;
               state_in = S_GCD_CHK;
            end
         end
         S_RED_N: begin
            if (div_done) begin
               num_in   = div_quo;
               go_in    = 1'b1;
               dvd_in   = den_ff;
               dvs_in   = x_ff;
               state_in = S_RED_D;
            end
         end
         S_RED_D: begin
            if (div_done) begin
               den_in   = div_quo;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            vld_in   = 1'b1;
            rst_in   = st_ff;
            if (st_ff == ST_OK) begin
               rnum_in = num_ff;
               rden_in = den_ff;
               rneg_in = neg_ff;
            end else begin
               rnum_in = '0;
               rden_in = '0;
               rneg_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      na_ff <= na_in; da_ff <= da_in; nb_ff <= nb_in; db_ff <= db_in;
      sa_ff <= sa_in; sb_ff <= sb_in; cmd_ff <= cmd_in;
      x_ff <= x_in; y_ff <= y_in; q1_ff <= q1_in; q2_ff <= q2_in;
      num_ff <= num_in; den_ff <= den_in; sl_ff <= sl_in;
      neg_ff <= neg_in; red_ff <= red_in; st_ff <= st_in;
      dvd_ff <= dvd_in; dvs_ff <= dvs_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rneg_ff <= rneg_in; rst_ff <= rst_in;
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         vld_ff   <= vld_in;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = vld_ff;
   assign rsp_result_num = rnum_ff;
   assign rsp_result_den = rden_ff;
   assign rsp_result_neg = rneg_ff;
   assign rsp_status     = rst_ff;

   // A response always lands while the sequencer is back in idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response shown while busy");

   // An accepted request always makes the block busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request accepted but not busy");

   // An error status carries an all-zero fraction.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_result_num == '0 && rsp_result_den == '0 && !rsp_result_neg))
      else $error("error response with nonzero payload");

   // A good result never has a zero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> (rsp_result_den != '0))
      else $error("zero denominator in good response");
endmodule
